>>> rtl/ascon_pkg.sv
// Shared types, constants and round helpers for the Ascon-128 AEAD core.
package ascon_pkg;

    localparam int unsigned ROUNDS_INIT_DEF = 12;
    localparam int unsigned ROUNDS_DATA_DEF = 6;
    localparam int unsigned RATE_BYTES = 8;
    localparam logic [63:0] ASCON_IV = 64'h80400c0600000000;
    localparam logic [63:0] PAD_TOP = 64'h8000000000000000;

    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_AD    = 3'd1;
    localparam logic [2:0] CMD_ENC   = 3'd2;
    localparam logic [2:0] CMD_DEC   = 3'd3;
    localparam logic [2:0] CMD_FIN   = 3'd4;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_AD   = 2'd1,
        PH_MSG  = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PERM,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] block;
        logic [3:0]  block_bytes;
        logic        is_last;
        logic [63:0] nonce_high;
        logic [63:0] nonce_low;
        logic [63:0] expected_high;
        logic [63:0] expected_low;
    } t_in_item;

    typedef struct packed {
        logic [63:0] out_block;
        logic [3:0]  out_bytes;
        logic [63:0] tag_high;
        logic [63:0] tag_low;
        logic        tag_match;
        logic        order_error;
    } t_out_item;

    typedef logic [4:0][63:0] t_state_words;

    // Round constant for round index r of 12.
    function automatic logic [7:0] round_const(input logic [3:0] r);
        logic [7:0] c;
        c = {4'hf - r, r};
        return c;
    endfunction

    function automatic logic [63:0] ror64(input logic [63:0] v, input int unsigned s);
        return (v >> s) | (v << (64 - s));
    endfunction

    function automatic logic [63:0] top_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) m[63-8*i -: 8] = 8'hff;
        end
        return m;
    endfunction

    function automatic logic [63:0] pad_at(input logic [3:0] n);
        logic [63:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) == n) p[63-8*i] = 1'b1;
        end
        return p;
    endfunction

endpackage

>>> rtl/ascon_round.sv
// One Ascon permutation round: constant addition, S-box layer, linear layer.
module ascon_round
    import ascon_pkg::*;
(
    input  t_state_words i_x,
    input  logic [3:0]   i_rnd,
    output t_state_words o_x
);
    logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;

    always_comb begin
        x0 = i_x[0]; x1 = i_x[1]; x2 = i_x[2]; x3 = i_x[3]; x4 = i_x[4];
        x2 = x2 ^ {56'd0, round_const(i_rnd)};
        x0 = x0 ^ x4; x4 = x4 ^ x3; x2 = x2 ^ x1;
        t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
        x0 = x0 ^ t1; x1 = x1 ^ t2; x2 = x2 ^ t3; x3 = x3 ^ t4; x4 = x4 ^ t0;
        x1 = x1 ^ x0; x0 = x0 ^ x4; x3 = x3 ^ x2; x2 = ~x2;
        o_x[0] = x0 ^ ror64(x0, 19) ^ ror64(x0, 28);
        o_x[1] = x1 ^ ror64(x1, 61) ^ ror64(x1, 39);
        o_x[2] = x2 ^ ror64(x2, 1) ^ ror64(x2, 6);
        o_x[3] = x3 ^ ror64(x3, 10) ^ ror64(x3, 17);
        o_x[4] = x4 ^ ror64(x4, 7) ^ ror64(x4, 41);
    end
endmodule

>>> rtl/ascon128_aead_core.sv
// Top level of the Ascon-128 AEAD core: command sequencer around one round unit.
//
// Channels: request channel (i_in_valid/o_in_ready, payload i_in of t_in_item),
// result channel (o_out_valid/i_out_ready, payload o_out of t_out_item), and a
// key write channel (i_cfg_valid/o_cfg_ready, index 0 key_high, 1 key_low).
// A single round unit runs one permutation round per clock.
// Work per accepted request:
//   start: a full permutation (12 rounds), no result.
//   associated data: one data permutation, or two for a full last block.
//   encrypt/decrypt: a full block runs one data permutation; a short last block none.
//   finalize: a full permutation, then the tag. Refused commands: an order error.
// Only one request is in flight; o_in_ready is low while a request is
// processed and while a result waits. A full message block passes ROUNDS_DATA
// rounds through the round unit, then the result state, then idle.
// The result is held in an output register until accepted; a stalled receiver
// stalls the core. Reset clears the state words, phase and key to zero.
module ascon128_aead_core
    import ascon_pkg::*;
#(
    parameter int unsigned ROUNDS_DATA = ROUNDS_DATA_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    localparam logic [3:0] DATA_START = 4'(12 - ROUNDS_DATA);

    t_state       r_state, n_state;
    t_phase       r_phase, n_phase;
    t_state_words r_x, n_x, w_rx;
    logic [63:0]  r_kh, r_kl;
    logic [3:0]   r_rnd, n_rnd;
    logic [2:0]   r_cmd, n_cmd;
    logic         r_extra, n_extra; // full last block: padding still due (AD: by a permutation)
    logic         r_emit, n_emit;
    logic [63:0]  r_exph, n_exph, r_expl, n_expl;
    t_out_item    r_out, n_out;

    ascon_round u_round (.i_x(r_x), .i_rnd(r_rnd), .o_x(w_rx));

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_out = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_IDLE;
            r_x <= '0;
            r_kh <= '0;
            r_kl <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_x <= n_x;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_KEY_HIGH) r_kh <= i_cfg_data;
                else r_kl <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rnd <= n_rnd;
        r_cmd <= n_cmd;
        r_extra <= n_extra;
        r_emit <= n_emit;
        r_exph <= n_exph;
        r_expl <= n_expl;
        r_out <= n_out;
    end

    always_comb begin
        logic [3:0]  n;
        logic [63:0] m, blk, th, tl;
        logic        full, dec;
        n_state = r_state; n_phase = r_phase; n_x = r_x; n_rnd = r_rnd;
        n_cmd = r_cmd; n_extra = r_extra; n_emit = r_emit;
        n_exph = r_exph; n_expl = r_expl; n_out = r_out;
        n = (i_in.block_bytes > 4'd8 || !i_in.is_last) ? 4'd8 : i_in.block_bytes;
        m = top_mask(n);
        blk = i_in.block & m;
        full = (n == 4'd8);
        dec = (i_in.cmd == CMD_DEC);
        th = w_rx[3] ^ r_kh;
        tl = w_rx[4] ^ r_kl;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_out = '0;
                    n_cmd = i_in.cmd;
                    n_extra = 1'b0;
                    n_emit = 1'b0;
                    n_exph = i_in.expected_high;
                    n_expl = i_in.expected_low;
                    if (i_in.cmd == CMD_START) begin
                        n_x = {i_in.nonce_low, i_in.nonce_high, r_kl, r_kh, ASCON_IV};
                        n_rnd = 4'd0;
                        n_phase = PH_AD;
                        n_state = ST_PERM;
                    end else if (i_in.cmd == CMD_AD && r_phase == PH_AD) begin
                        n_rnd = DATA_START;
                        if (full) begin
                            n_x[0] = r_x[0] ^ i_in.block;
                            n_extra = i_in.is_last;
                        end else begin
                            n_x[0] = r_x[0] ^ blk ^ pad_at(n);
                        end
                        if (i_in.is_last) n_phase = PH_MSG;
                        n_state = ST_PERM;
                    end else if ((i_in.cmd == CMD_ENC || i_in.cmd == CMD_DEC) &&
                                 (r_phase == PH_AD || r_phase == PH_MSG)) begin
                        if (r_phase == PH_AD) n_x[4] = r_x[4] ^ 64'd1;
                        n_out.out_bytes = n;
                        n_out.out_block = (r_x[0] ^ blk) & m;
                        if (dec) n_x[0] = blk | (r_x[0] & ~m);
                        else n_x[0] = r_x[0] ^ blk;
                        n_phase = i_in.is_last ? PH_DONE : PH_MSG;
                        n_emit = 1'b1;
                        n_rnd = DATA_START;
                        if (full) begin
                            n_extra = i_in.is_last;
                            n_state = ST_PERM;
                        end else begin
                            n_x[0] = n_x[0] ^ pad_at(n);
                            n_state = ST_OUT;
                        end
                    end else if (i_in.cmd == CMD_FIN && r_phase == PH_DONE) begin
                        n_x[1] = r_x[1] ^ r_kh;
                        n_x[2] = r_x[2] ^ r_kl;
                        n_rnd = 4'd0;
                        n_phase = PH_IDLE;
                        n_emit = 1'b1;
                        n_state = ST_PERM;
                    end else begin
                        n_out.order_error = 1'b1;
                        n_state = ST_OUT;
                    end
                end
            end
            ST_PERM: begin
                n_x = w_rx;
                n_rnd = r_rnd + 4'd1;
                if (r_rnd == 4'd11) begin
                    if (r_cmd == CMD_START) begin
                        n_x[3] = w_rx[3] ^ r_kh;
                        n_x[4] = w_rx[4] ^ r_kl;
                        n_state = ST_IDLE;
                    end else if (r_cmd == CMD_FIN) begin
                        n_out.tag_high = th;
                        n_out.tag_low = tl;
                        n_out.tag_match = (th == r_exph) && (tl == r_expl);
                        n_state = ST_OUT;
                    end else if (r_extra && r_cmd == CMD_AD) begin
                        n_x[0] = w_rx[0] ^ PAD_TOP;
                        n_extra = 1'b0;
                        n_rnd = DATA_START;
                    end else begin
                        if (r_extra) n_x[0] = w_rx[0] ^ PAD_TOP;
                        if (r_cmd == CMD_AD && r_phase == PH_MSG)
                            n_x[4] = w_rx[4] ^ 64'd1;
                        n_state = r_emit ? ST_OUT : ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

>>> rtl/ascon_checker.sv
// Port-level assertions for the Ascon-128 AEAD core, bound to the top level.
module ascon_checker
    import ascon_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("request taken while result pending");
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.order_error |-> o_out.out_bytes == 4'd0 && !o_out.tag_match)
        else $error("order error with data");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after accept");
endmodule

bind ascon128_aead_core ascon_checker u_checker (.*);
